FILE: sv/ifp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg - shared definitions for the infix to postfix converter
// Token codes, priorities, status codes and the classified item that travels
// from the front queue to the stack engine.
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned BITS_W = 64;
  localparam int unsigned PRIO_W = 3;
  localparam int unsigned STAT_W = 2;

  // Token codes
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd0;
  localparam logic [KIND_W-1:0] K_X      = 5'd1;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd2;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd3;
  localparam logic [KIND_W-1:0] K_UMINUS = 5'd4;
  localparam logic [KIND_W-1:0] K_UPLUS  = 5'd5;
  localparam logic [KIND_W-1:0] K_MUL    = 5'd6;
  localparam logic [KIND_W-1:0] K_MOD    = 5'd8;
  localparam logic [KIND_W-1:0] K_FN_LO  = 5'd9;
  localparam logic [KIND_W-1:0] K_FN_HI  = 5'd17;
  localparam logic [KIND_W-1:0] K_POW    = 5'd18;
  localparam logic [KIND_W-1:0] K_OPEN   = 5'd19;
  localparam logic [KIND_W-1:0] K_CLOSE  = 5'd20;
  localparam logic [KIND_W-1:0] K_TOP    = 5'd31;

  // Priorities
  localparam logic [PRIO_W-1:0] PRIO_NONE = 3'd0;
  localparam logic [PRIO_W-1:0] PRIO_ADD  = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MUL  = 3'd2;
  localparam logic [PRIO_W-1:0] PRIO_FN   = 3'd3;
  localparam logic [PRIO_W-1:0] PRIO_POW  = 3'd4;
  localparam logic [PRIO_W-1:0] PRIO_OPEN = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_CLOSE = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  // What the stack engine has to do with an item
  typedef enum logic [2:0] {
    CMD_EMIT,
    CMD_CLOSE,
    CMD_OP,
    CMD_UMINUS,
    CMD_SKIP
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KIND_W-1:0] kind;
    logic [BITS_W-1:0] bits;
    logic [PRIO_W-1:0] prio;
    logic              last;
  } item_t;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [PRIO_W-1:0] prio_of(input logic [KIND_W-1:0] k);
    logic [PRIO_W-1:0] p;
    p = PRIO_NONE;
    case (k) inside
      [K_PLUS:K_UPLUS]:  p = PRIO_ADD;
      [K_MUL:K_MOD]:     p = PRIO_MUL;
      [K_FN_LO:K_FN_HI]: p = PRIO_FN;
      K_POW:             p = PRIO_POW;
      [K_OPEN:K_TOP]:    p = PRIO_OPEN;
      default:           p = PRIO_NONE;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/ifp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_in_if - infix token channel
// Valid/ready channel carrying one infix token per item.
// ----------------------------------------------------------------------------
interface ifp_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifp_pkg::KIND_W-1:0]  kind;
  logic [ifp_pkg::BITS_W-1:0]  number_bits;
  logic                        end_of_expression;

  modport source (output valid, kind, number_bits, end_of_expression, input ready);
  modport sink   (input valid, kind, number_bits, end_of_expression, output ready);
endinterface

FILE: sv/ifp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_out_if - postfix token channel
// Valid/ready channel carrying one postfix token or the terminator per item.
// ----------------------------------------------------------------------------
interface ifp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ifp_pkg::KIND_W-1:0]  out_kind;
  logic [ifp_pkg::BITS_W-1:0]  out_number_bits;
  logic                        token_valid;
  logic                        end_of_output;
  logic [ifp_pkg::STAT_W-1:0]  status;

  modport source (output valid, out_kind, out_number_bits, token_valid, end_of_output,
                  status, input ready);
  modport sink   (input valid, out_kind, out_number_bits, token_valid, end_of_output,
                  status, output ready);
endinterface

FILE: sv/ifp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front - token intake and classification
// Accepts infix tokens, decodes each into a command for the stack engine and
// holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module ifp_front (
  input  logic                clk,
  input  logic                rst,
  ifp_in_if.sink              src,
  output ifp_pkg::q_head_t    head,
  input  logic                deq
);

  ifp_pkg::item_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  ifp_pkg::item_t cls;
  logic           enq;

  // Classify the incoming token
  always_comb begin
    cls.kind = src.kind;
    cls.bits = '0;
    cls.prio = ifp_pkg::prio_of(src.kind);
    cls.last = src.end_of_expression;
    case (src.kind) inside
      ifp_pkg::K_NUMBER: begin
        cls.cmd  = ifp_pkg::CMD_EMIT;
        cls.bits = src.number_bits;
      end
      ifp_pkg::K_X:      cls.cmd = ifp_pkg::CMD_EMIT;
      ifp_pkg::K_UMINUS: begin
        cls.cmd  = ifp_pkg::CMD_UMINUS;
        cls.kind = ifp_pkg::K_MINUS;
      end
      ifp_pkg::K_UPLUS:  cls.cmd = ifp_pkg::CMD_SKIP;
      ifp_pkg::K_CLOSE:  cls.cmd = ifp_pkg::CMD_CLOSE;
      [ifp_pkg::K_PLUS:ifp_pkg::K_OPEN]: cls.cmd = ifp_pkg::CMD_OP;
      default:           cls.cmd = ifp_pkg::CMD_SKIP;
    endcase
  end

  assign src.ready  = (fill != 2'd2);
  assign enq        = src.valid && src.ready;
  assign head.valid = (fill != 2'd0);
  assign head.item  = q[rd_ptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

FILE: sv/ifp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_back - operator stack engine
// Carries out one queued command a step at a time: pops, pushes, the unary
// zero, the final flush and the terminator, through a registered output.
// ----------------------------------------------------------------------------
module ifp_back #(
  parameter int unsigned STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ifp_pkg::q_head_t    head,
  output logic                deq,
  ifp_out_if.source           dst
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_FLUSH,
    PH_TERM
  } phase_t;

  phase_t                      phase;
  logic [CNT_W-1:0]            count;
  logic [ifp_pkg::STAT_W-1:0]  err;
  logic                        zero_done;
  logic [ifp_pkg::KIND_W-1:0]  stack [STACK_DEPTH];

  logic                        out_valid;
  logic [ifp_pkg::KIND_W-1:0]  out_kind;
  logic [ifp_pkg::BITS_W-1:0]  out_bits;
  logic                        out_tv;
  logic                        out_end;
  logic [ifp_pkg::STAT_W-1:0]  out_status;

  logic [IDX_W-1:0]            top_idx;
  logic [IDX_W-1:0]            push_idx;
  logic [ifp_pkg::KIND_W-1:0]  top;
  logic                        pop_ok;
  logic                        can_load;
  logic                        emit;
  logic [ifp_pkg::KIND_W-1:0]  e_kind;
  logic [ifp_pkg::BITS_W-1:0]  e_bits;
  logic                        e_tv;
  logic                        e_end;
  logic                        pop;
  logic                        push;
  logic                        set_err;
  logic [ifp_pkg::STAT_W-1:0]  err_val;
  logic                        zero_set;
  logic                        tok_done;
  logic                        to_term;
  logic                        term_done;
  logic                        full;

  assign top_idx  = IDX_W'(count - CNT_W'(1));
  assign push_idx = IDX_W'(count);
  assign top      = stack[top_idx];
  assign pop_ok   = (count != '0) && (top != ifp_pkg::K_OPEN);
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign can_load = !out_valid || dst.ready;

  // Decide this cycle's step
  always_comb begin
    emit      = 1'b0;
    e_kind    = top;
    e_bits    = '0;
    e_tv      = 1'b1;
    e_end     = 1'b0;
    pop       = 1'b0;
    push      = 1'b0;
    set_err   = 1'b0;
    err_val   = ifp_pkg::ST_OK;
    zero_set  = 1'b0;
    tok_done  = 1'b0;
    to_term   = 1'b0;
    term_done = 1'b0;
    case (phase)
      PH_MAIN: begin
        if (head.valid) begin
          if (err != ifp_pkg::ST_OK) begin
            // error pending: token ignored
            tok_done = 1'b1;
          end else begin
            case (head.item.cmd)
              ifp_pkg::CMD_EMIT: begin
                emit     = 1'b1;
                e_kind   = head.item.kind;
                e_bits   = head.item.bits;
                tok_done = can_load;
              end
              ifp_pkg::CMD_CLOSE: begin
                if (pop_ok) begin
                  emit = 1'b1;
                  pop  = can_load;
                end else if (count == '0) begin
                  set_err  = 1'b1;
                  err_val  = ifp_pkg::ST_CLOSE;
                  tok_done = 1'b1;
                end else begin
                  // drop the matching open bracket
                  pop      = 1'b1;
                  tok_done = 1'b1;
                end
              end
              ifp_pkg::CMD_OP, ifp_pkg::CMD_UMINUS: begin
                if (head.item.prio != ifp_pkg::PRIO_OPEN && pop_ok &&
                    head.item.prio <= ifp_pkg::prio_of(top)) begin
                  emit = 1'b1;
                  pop  = can_load;
                end else if (head.item.cmd == ifp_pkg::CMD_UMINUS && !zero_done) begin
                  emit     = 1'b1;
                  e_kind   = ifp_pkg::K_NUMBER;
                  zero_set = can_load;
                end else begin
                  if (full) begin
                    set_err = 1'b1;
                    err_val = ifp_pkg::ST_OVF;
                  end else begin
                    push = 1'b1;
                  end
                  tok_done = 1'b1;
                end
              end
              default: tok_done = 1'b1;
            endcase
          end
        end
      end
      PH_FLUSH: begin
        if (err == ifp_pkg::ST_OK && count != '0) begin
          emit = 1'b1;
          pop  = can_load;
        end else begin
          to_term = 1'b1;
        end
      end
      PH_TERM: begin
        emit      = 1'b1;
        e_kind    = ifp_pkg::K_NUMBER;
        e_tv      = 1'b0;
        e_end     = 1'b1;
        term_done = can_load;
      end
      default: begin
      end
    endcase
  end

  assign deq = (tok_done && !head.item.last) || term_done;

  // State, stack and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_MAIN;
      count     <= '0;
      err       <= ifp_pkg::ST_OK;
      zero_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit && can_load) begin
        out_valid  <= 1'b1;
        out_kind   <= e_kind;
        out_bits   <= e_bits;
        out_tv     <= e_tv;
        out_end    <= e_end;
        out_status <= e_end ? err : ifp_pkg::ST_OK;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end

      if (push) begin
        stack[push_idx] <= head.item.kind;
      end

      if (term_done) begin
        count <= '0;
      end else if (pop) begin
        count <= count - CNT_W'(1);
      end else if (push) begin
        count <= count + CNT_W'(1);
      end

      if (term_done) begin
        err <= ifp_pkg::ST_OK;
      end else if (set_err) begin
        err <= err_val;
      end

      if (deq) begin
        zero_done <= 1'b0;
      end else if (zero_set) begin
        zero_done <= 1'b1;
      end

      case (phase)
        PH_MAIN:  if (tok_done && head.item.last) phase <= PH_FLUSH;
        PH_FLUSH: if (to_term) phase <= PH_TERM;
        PH_TERM:  if (term_done) phase <= PH_MAIN;
        default:  phase <= PH_MAIN;
      endcase
    end
  end

  assign dst.valid           = out_valid;
  assign dst.out_kind        = out_kind;
  assign dst.out_number_bits = out_bits;
  assign dst.token_valid     = out_tv;
  assign dst.end_of_output   = out_end;
  assign dst.status          = out_status;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push onto a full operator stack");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    term_done |=> (count == '0) && (err == ifp_pkg::ST_OK))
    else $error("stack or error not cleared after terminator");

  a_token_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_tv) |-> (out_status == ifp_pkg::ST_OK) && !out_end)
    else $error("token item carries status or end mark");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from an empty operator stack");

endmodule

FILE: sv/infix_to_postfix_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit - shunting-yard token converter
// Turns a stream of infix tokens into postfix tokens with an operator stack
// and closes each expression with a status item.
// ----------------------------------------------------------------------------
// Tokens enter through a two-entry queue and are handled by the stack engine
// one step per cycle. Numbers and x are emitted directly; unary plus and
// unused codes are dropped without output. An operator, function, unary minus
// or close bracket first pops operators one at a time; a unary minus then
// emits the inserted zero; last the token is pushed, the bracket dropped or
// the error flagged. An open bracket pops nothing and is pushed directly.
// After the final token the engine flushes the remaining operators one at a
// time, leaves the flush and sends the terminator. A stalled output holds the
// engine whenever it has a token to emit; the queue then keeps the token in
// hand and takes one more before it stalls the input. Status is 0 ok, 1
// unmatched close bracket, 2 operator stack overflow; after an error the
// remaining tokens of the expression are dropped and only the terminator is
// sent.
module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ifp_in_if.sink     src,
  ifp_out_if.source  dst
);

  ifp_pkg::q_head_t head;
  logic             deq;

  ifp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .src  (src),
    .head (head),
    .deq  (deq)
  );

  ifp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .deq  (deq),
    .dst  (dst)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the infix to postfix converter
// Drives infix token items into the converter with random bursts and gaps,
// stalls the postfix side on its own pattern, and checks every postfix item
// against an in-bench shunting-yard predictor. Directed expressions cover
// operand extremes, every operator, unary handling, bracket errors, stack
// overflow and the unused token codes; random well-formed expressions with
// some broken ones make up the bulk of the run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH        = ifp_pkg::STACK_DEPTH_DEF;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 100;

  // Token codes the package leaves unnamed
  localparam logic [ifp_pkg::KIND_W-1:0] KIND_DIV   = 5'd7;
  localparam logic [ifp_pkg::KIND_W-1:0] KIND_SPARE = 5'd21;

  typedef struct packed {
    logic [ifp_pkg::KIND_W-1:0] kind;
    logic [ifp_pkg::BITS_W-1:0] bits;
    logic                       last;
  } infix_t;

  typedef struct packed {
    logic [ifp_pkg::KIND_W-1:0] kind;
    logic [ifp_pkg::BITS_W-1:0] bits;
    logic                       tok;
    logic                       eoo;
    logic [ifp_pkg::STAT_W-1:0] st;
  } postfix_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_SELDOM,
    RDY_PATTERN
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Drivers of the block's inputs, known from time zero
  logic                       src_valid = 1'b0;
  logic [ifp_pkg::KIND_W-1:0] src_kind  = '0;
  logic [ifp_pkg::BITS_W-1:0] src_bits  = '0;
  logic                       src_last  = 1'b0;
  logic                       sink_ready = 1'b0;

  ifp_in_if  src_if ();
  ifp_out_if dst_if ();

  assign src_if.valid             = src_valid;
  assign src_if.kind              = src_kind;
  assign src_if.number_bits       = src_bits;
  assign src_if.end_of_expression = src_last;
  assign dst_if.ready             = sink_ready;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .src(src_if),
    .dst(dst_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [ifp_pkg::KIND_W-1:0] op_stack [DEPTH];
  int unsigned                op_depth = 0;
  logic [ifp_pkg::STAT_W-1:0] expr_status = ifp_pkg::ST_OK;
  postfix_t                   postfix_expected [$];

  // Stimulus staging
  infix_t            infix_q [$];
  int                burst_left = 0;

  // Bookkeeping
  int unsigned       cycle_count = 0;
  int                mismatches = 0;
  int                results_checked = 0;
  int                tokens_sent = 0;
  int                expressions_sent = 0;
  int                status_seen [3] = '{0, 0, 0};

  // Receiver stall control
  stall_mode_t       rdy_mode = RDY_ALWAYS;
  int                window_left = 0;
  logic [15:0]       rdy_pattern = 16'b1011_0111_0010_1101;
  logic              hold_on = 1'b0;
  event              start_hold;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [ifp_pkg::PRIO_W-1:0] rank(input logic [ifp_pkg::KIND_W-1:0] k);
    if (k >= ifp_pkg::K_PLUS && k <= ifp_pkg::K_UPLUS) return ifp_pkg::PRIO_ADD;
    if (k >= ifp_pkg::K_MUL && k <= ifp_pkg::K_MOD) return ifp_pkg::PRIO_MUL;
    if (k >= ifp_pkg::K_FN_LO && k <= ifp_pkg::K_FN_HI) return ifp_pkg::PRIO_FN;
    if (k == ifp_pkg::K_POW) return ifp_pkg::PRIO_POW;
    if (k >= ifp_pkg::K_OPEN) return ifp_pkg::PRIO_OPEN;
    return ifp_pkg::PRIO_NONE;
  endfunction

  function automatic void add_postfix(input logic [ifp_pkg::KIND_W-1:0] kind,
                                      input logic [ifp_pkg::BITS_W-1:0] bits,
                                      input logic tok, input logic eoo,
                                      input logic [ifp_pkg::STAT_W-1:0] st);
    postfix_t p;
    p = '{kind: kind, bits: bits, tok: tok, eoo: eoo, st: st};
    postfix_expected.push_back(p);
  endfunction

  function automatic void pop_operator();
    op_depth--;
    add_postfix(op_stack[op_depth], '0, 1'b1, 1'b0, ifp_pkg::ST_OK);
  endfunction

  function automatic void convert_token(input logic [ifp_pkg::KIND_W-1:0] kind,
                                        input logic [ifp_pkg::BITS_W-1:0] bits,
                                        input logic last);
    logic [ifp_pkg::KIND_W-1:0] k;
    logic [ifp_pkg::PRIO_W-1:0] p;
    k = kind;
    p = rank(k);
    // after an error the rest of the expression is dropped
    if (expr_status == ifp_pkg::ST_OK) begin
      if (k == ifp_pkg::K_CLOSE) begin
        while (op_depth > 0 && op_stack[op_depth-1] != ifp_pkg::K_OPEN) pop_operator();
        if (op_depth == 0) expr_status = ifp_pkg::ST_CLOSE;
        else op_depth--;
      end else if (k == ifp_pkg::K_NUMBER) begin
        add_postfix(k, bits, 1'b1, 1'b0, ifp_pkg::ST_OK);
      end else if (k == ifp_pkg::K_X) begin
        add_postfix(k, '0, 1'b1, 1'b0, ifp_pkg::ST_OK);
      end else if (k != ifp_pkg::K_UPLUS && k <= ifp_pkg::K_CLOSE) begin
        // open bracket never pops; others pop while top ranks at least as high
        if (p != ifp_pkg::PRIO_OPEN) begin
          while (op_depth > 0 && op_stack[op_depth-1] != ifp_pkg::K_OPEN &&
                 p <= rank(op_stack[op_depth-1]))
            pop_operator();
        end
        if (k == ifp_pkg::K_UMINUS) begin
          add_postfix(ifp_pkg::K_NUMBER, '0, 1'b1, 1'b0, ifp_pkg::ST_OK);
          k = ifp_pkg::K_MINUS;
        end
        if (op_depth >= DEPTH) expr_status = ifp_pkg::ST_OVF;
        else begin
          op_stack[op_depth] = k;
          op_depth++;
        end
      end
    end
    // final token: flush unless in error, then the status terminator
    if (last) begin
      if (expr_status == ifp_pkg::ST_OK) begin
        while (op_depth > 0) pop_operator();
      end
      add_postfix(ifp_pkg::K_NUMBER, '0, 1'b0, 1'b1, expr_status);
      op_depth = 0;
      expr_status = ifp_pkg::ST_OK;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_token(input infix_t t);
    if (burst_left <= 0) begin
      // gap between bursts, sometimes none at all
      if ($urandom_range(0, 3) != 0) begin
        src_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    src_valid <= 1'b1;
    src_kind  <= t.kind;
    src_bits  <= t.bits;
    src_last  <= t.last;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    tokens_sent++;
    if (t.last) expressions_sent++;
    convert_token(t.kind, t.bits, t.last);
  endtask

  task automatic send_expression();
    foreach (infix_q[i]) send_token(infix_q[i]);
    infix_q.delete();
  endtask

  function automatic void add_infix(input logic [ifp_pkg::KIND_W-1:0] kind,
                                    input logic [ifp_pkg::BITS_W-1:0] bits = '0);
    infix_t t;
    t = '{kind: kind, bits: bits, last: 1'b0};
    infix_q.push_back(t);
  endfunction

  function automatic void close_expression();
    infix_q[infix_q.size()-1].last = 1'b1;
  endfunction

  task automatic wait_until_drained();
    src_valid <= 1'b0;
    while (postfix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random expression builder
  // --------------------------------------------------------------------------
  function automatic logic [ifp_pkg::BITS_W-1:0] rand_bits();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ifp_pkg::KIND_W-1:0] pick_binop();
    case ($urandom_range(0, 5))
      0:       return ifp_pkg::K_PLUS;
      1:       return ifp_pkg::K_MINUS;
      2:       return ifp_pkg::K_MUL;
      3:       return KIND_DIV;
      4:       return ifp_pkg::K_MOD;
      default: return ifp_pkg::K_POW;
    endcase
  endfunction

  function automatic logic [ifp_pkg::KIND_W-1:0] pick_function();
    return ifp_pkg::KIND_W'($urandom_range(ifp_pkg::K_FN_LO, ifp_pkg::K_FN_HI));
  endfunction

  // Well-formed expression: operands, binary operators, unary prefixes,
  // brackets and function calls nested up to max_depth.
  function automatic void build_expression(input int max_depth, input int open_pct,
                                           input int target_len);
    int  open_n;
    bit  need_operand;
    bit  done;
    int  r;
    open_n = 0;
    need_operand = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (need_operand) begin
        r = $urandom_range(0, 99);
        if (r < 10 && infix_q.size() < target_len) begin
          add_infix($urandom_range(0, 1) ? ifp_pkg::K_UMINUS : ifp_pkg::K_UPLUS);
        end else if (r < 10 + open_pct && open_n < max_depth &&
                     infix_q.size() < target_len) begin
          if ($urandom_range(0, 1)) add_infix(pick_function());
          add_infix(ifp_pkg::K_OPEN);
          open_n++;
        end else begin
          if ($urandom_range(0, 4) == 0) add_infix(ifp_pkg::K_X, rand_bits());
          else add_infix(ifp_pkg::K_NUMBER, rand_bits());
          need_operand = 1'b0;
        end
      end else if (open_n > 0 &&
                   ($urandom_range(0, 2) == 0 || infix_q.size() >= target_len)) begin
        add_infix(ifp_pkg::K_CLOSE);
        open_n--;
      end else if (infix_q.size() >= target_len) begin
        done = 1'b1;
      end else begin
        add_infix(pick_binop());
        need_operand = 1'b1;
      end
    end
    close_expression();
  endfunction

  // Broken expression: some tokens swapped for any code, any payload
  function automatic void corrupt_expression();
    foreach (infix_q[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        infix_q[i].kind = ifp_pkg::KIND_W'($urandom_range(0, 31));
        infix_q[i].bits = rand_bits();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Operand extremes and every binary operator, with equal-rank pops
  task automatic test_operators();
    add_infix(ifp_pkg::K_NUMBER, '0);
    add_infix(ifp_pkg::K_PLUS);
    add_infix(ifp_pkg::K_NUMBER, '1);
    add_infix(ifp_pkg::K_MUL);
    add_infix(ifp_pkg::K_X, '1);
    add_infix(ifp_pkg::K_POW);
    add_infix(ifp_pkg::K_NUMBER, 64'h8000_0000_0000_0000);
    add_infix(ifp_pkg::K_MINUS);
    add_infix(ifp_pkg::K_NUMBER, 64'h5555_5555_5555_5555);
    add_infix(KIND_DIV);
    add_infix(ifp_pkg::K_NUMBER, 64'hAAAA_AAAA_AAAA_AAAA);
    add_infix(ifp_pkg::K_MOD);
    add_infix(ifp_pkg::K_NUMBER, 64'd1);
    close_expression();
    send_expression();
  endtask

  // Leading unary minus, dropped unary plus, function calls in brackets
  task automatic test_unary_and_functions();
    add_infix(ifp_pkg::K_UMINUS);
    add_infix(ifp_pkg::K_FN_LO);
    add_infix(ifp_pkg::K_OPEN);
    add_infix(ifp_pkg::K_X);
    add_infix(ifp_pkg::K_CLOSE);
    add_infix(ifp_pkg::K_MUL);
    add_infix(ifp_pkg::K_UPLUS);
    add_infix(ifp_pkg::K_FN_HI);
    add_infix(ifp_pkg::K_OPEN);
    add_infix(ifp_pkg::K_NUMBER, 64'h0123_4567_89AB_CDEF);
    add_infix(ifp_pkg::K_CLOSE);
    add_infix(ifp_pkg::K_POW);
    add_infix(ifp_pkg::K_NUMBER, 64'hFEDC_BA98_7654_3210);
    close_expression();
    send_expression();
  endtask

  // Close bracket with no open one; the rest is ignored
  task automatic test_unmatched_close();
    add_infix(ifp_pkg::K_NUMBER, 64'd7);
    add_infix(ifp_pkg::K_PLUS);
    add_infix(ifp_pkg::K_NUMBER, 64'd9);
    add_infix(ifp_pkg::K_CLOSE);
    add_infix(ifp_pkg::K_MUL);
    add_infix(ifp_pkg::K_NUMBER, 64'd3);
    close_expression();
    send_expression();
  endtask

  // Codes above close bracket are dropped; end flag still closes the expression
  task automatic test_unused_codes();
    add_infix(KIND_SPARE, '1);
    add_infix(ifp_pkg::K_NUMBER, 64'd42);
    add_infix(ifp_pkg::K_TOP, '1);
    close_expression();
    send_expression();
  endtask

  // Fill the operator stack up to an open bracket on top, then push once more
  // with unary minus
  task automatic test_stack_overflow();
    bit prev_fn;
    prev_fn = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!prev_fn && i > 0 && i < int'(DEPTH) - 1 && $urandom_range(0, 1)) begin
        add_infix(pick_function());
        prev_fn = 1'b1;
      end else begin
        add_infix(ifp_pkg::K_OPEN);
        prev_fn = 1'b0;
      end
    end
    add_infix(ifp_pkg::K_UMINUS);
    add_infix(ifp_pkg::K_NUMBER, rand_bits());
    add_infix(ifp_pkg::K_CLOSE);
    add_infix(ifp_pkg::K_NUMBER, rand_bits());
    close_expression();
    send_expression();
  endtask

  // Long output stall while the sender keeps offering tokens
  task automatic test_output_hold();
    -> start_hold;
    burst_left = 1000;
    build_expression(3, 15, 24);
    send_expression();
    burst_left = 0;
  endtask

  task automatic test_random();
    int start;
    start = tokens_sent;
    while (tokens_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) build_expression(20, 80, 30);
      else build_expression($urandom_range(1, 5), 25, $urandom_range(1, 14));
      if ($urandom_range(0, 6) == 0) corrupt_expression();
      send_expression();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall modes per window, plus the long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (window_left <= 0) begin
      rdy_mode    <= stall_mode_t'($urandom_range(0, 3));
      window_left <= $urandom_range(16, 128);
    end else begin
      window_left <= window_left - 1;
    end
    rdy_pattern <= {rdy_pattern[14:0], rdy_pattern[15]};
    if (rst || hold_on) begin
      sink_ready <= 1'b0;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS:  sink_ready <= 1'b1;
        RDY_MOSTLY:  sink_ready <= ($urandom_range(0, 3) != 0);
        RDY_SELDOM:  sink_ready <= ($urandom_range(0, 3) == 0);
        default:     sink_ready <= rdy_pattern[15];
      endcase
    end
  end

  // Hold-off length counted here
  initial begin : hold_off
    forever begin
      @(start_hold);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_postfix(input postfix_t got);
    postfix_t want;
    bit       bad;
    results_checked++;
    if (!got.tok && got.eoo && got.st <= ifp_pkg::ST_OVF) status_seen[got.st]++;
    if (postfix_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected item: kind %0d bits %h tok %b end %b status %0d",
                 $realtime, got.kind, got.bits, got.tok, got.eoo, got.st);
      return;
    end
    want = postfix_expected.pop_front();
    bad = (got.kind !== want.kind) || (got.bits !== want.bits) ||
          (got.tok !== want.tok) || (got.eoo !== want.eoo) || (got.st !== want.st);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch on item %0d", $realtime, results_checked);
        $display("  expected: kind %0d bits %h tok %b end %b status %0d",
                 want.kind, want.bits, want.tok, want.eoo, want.st);
        $display("  actual:   kind %0d bits %h tok %b end %b status %0d",
                 got.kind, got.bits, got.tok, got.eoo, got.st);
      end
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && dst_if.valid && dst_if.ready)
      check_postfix('{kind: dst_if.out_kind, bits: dst_if.out_number_bits,
                      tok: dst_if.token_valid, eoo: dst_if.end_of_output,
                      st: dst_if.status});
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("Timed out after %0d cycles, %0d items still awaited",
             cycle_count, postfix_expected.size());
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operators();
    test_unary_and_functions();
    test_unmatched_close();
    test_unused_codes();
    test_stack_overflow();
    test_output_hold();
    test_random();
    wait_until_drained();

    if (postfix_expected.size() != 0) mismatches++;
    $display("Sent %0d tokens in %0d expressions, checked %0d postfix items",
             tokens_sent, expressions_sent, results_checked);
    $display("Terminators: %0d ok, %0d unmatched close, %0d overflow; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
